// ===== src/doubly_linked_list_engine_core_macros.svh =====
// Assertion macros shared by the list engine. The bodies assume a clock named clk
// and an active-high reset named rst in the module that uses them.
`ifndef DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define DLL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define DLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DLL_ASSERT_NOW(label, ante, cons)
`define DLL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/dll_pkg.sv =====
package dll_pkg;

  // Fixed field widths of the request and response transfers.
  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int HND_W  = 6;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_HEAD  = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_TAIL  = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_NODE  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_AFTER,
    S_NODE_WR,
    S_LINK,
    S_UNLINK,
    S_FIND,
    S_DONE
  } state_t;

endpackage

// ===== src/dll_req_if.sv =====
interface dll_req_if;
  logic                                valid;
  logic                                ready;
  logic [dll_pkg::OP_W-1:0]            op;
  logic signed [dll_pkg::VAL_W-1:0]    new_value;
  logic [dll_pkg::HND_W-1:0]           node_handle;

  modport source (output valid, op, new_value, node_handle, input ready);
  modport sink (input valid, op, new_value, node_handle, output ready);
endinterface

// ===== src/dll_rsp_if.sv =====
interface dll_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dll_pkg::STAT_W-1:0]    status;
  logic [dll_pkg::HND_W-1:0]     result_handle;
  logic [dll_pkg::CNT_W-1:0]     list_count;

  modport source (output valid, status, result_handle, list_count, input ready);
  modport sink (input valid, status, result_handle, list_count, output ready);
endinterface

// ===== src/doubly_linked_list_engine_core.sv =====
// Channel  Dir  Fields                              Transfer
// req      in   op, new_value, node_handle          valid && ready
// rsp      out  status, result_handle, list_count   valid && ready
//
// Inserts at head or tail write the new node, then link it; insert after first reads the
// given node's next link. The allocator then scans for the next free entry, and no new
// request is taken until it ends. Find walks from the head, one node memory read each.
// Deletes read the node, then unlink it; failed requests and unused codes go to done.
// Reset clears the allocation bits, head, tail and count; the node memory is not cleared.
// A new request is taken while a response waits; the sequencer stalls in its last state.
`include "doubly_linked_list_engine_core_macros.svh"

module doubly_linked_list_engine_core #(
  parameter int POOL_DEPTH = 64
) (
  input  logic   clk,
  input  logic   rst,
  dll_req_if.sink   req,
  dll_rsp_if.source rsp
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  dll_pkg::state_t state, state_next;

  logic [dll_pkg::OP_W-1:0]   op_q;
  logic [dll_pkg::VAL_W-1:0]  val_q;
  logic [dll_pkg::HND_W-1:0]  h_q;
  logic [LW-1:0]              n_q, a_q, b_q;
  logic [LW-1:0]              head, tail, count;
  logic [dll_pkg::STAT_W-1:0] status_q;
  logic [LW-1:0]              res_q;

  logic                       out_valid;
  logic [dll_pkg::STAT_W-1:0] out_status;
  logic [dll_pkg::HND_W-1:0]  out_handle;
  logic [dll_pkg::CNT_W-1:0]  out_count;

  logic [IW-1:0]              raddr;
  logic [dll_pkg::VAL_W-1:0]  rd_value;
  logic [LW-1:0]              rd_next, rd_prev;
  logic                       value_we, next_we, prev_we;
  logic [IW-1:0]              value_waddr, next_waddr, prev_waddr;
  logic [LW-1:0]              next_wdata, prev_wdata;

  logic                       set_en, clr_en;
  logic [IW-1:0]              clr_idx;
  logic                       q_used;
  logic [LW-1:0]              lowest;
  logic                       alloc_busy;

  logic                       list_empty, pool_full, h_ok, out_free;

  dll_node_mem #(.DEPTH(POOL_DEPTH), .LW(LW)) u_mem (
    .clk        (clk),
    .raddr      (raddr),
    .rd_value   (rd_value),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev),
    .value_we   (value_we),
    .value_waddr(value_waddr),
    .value_wdata(val_q),
    .next_we    (next_we),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_we    (prev_we),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata)
  );

  dll_alloc #(.DEPTH(POOL_DEPTH), .LW(LW)) u_alloc (
    .clk    (clk),
    .rst    (rst),
    .set_en (set_en),
    .clr_en (clr_en),
    .clr_idx(clr_idx),
    .q_idx  (IW'(h_q)),
    .q_used (q_used),
    .lowest (lowest),
    .busy   (alloc_busy)
  );

  // Conditions checked when a request is decoded, and whether the response register is free.
  assign list_empty = (count == '0);
  assign pool_full  = (lowest == NIL);
  assign h_ok       = (32'(h_q) < 32'(POOL_DEPTH)) && q_used;
  assign out_free   = !out_valid || rsp.ready;

  assign req.ready         = (state == dll_pkg::S_IDLE) && !alloc_busy;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.result_handle = out_handle;
  assign rsp.list_count    = out_count;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dll_pkg::S_IDLE: begin
        if (req.valid && req.ready) begin
          state_next = dll_pkg::S_EXEC;
        end
      end
      dll_pkg::S_EXEC: begin
        state_next = dll_pkg::S_DONE;
        case (op_q)
          dll_pkg::OP_INS_HEAD, dll_pkg::OP_INS_TAIL: begin
            if (!pool_full) begin
              state_next = dll_pkg::S_NODE_WR;
            end
          end
          dll_pkg::OP_INS_AFTER: begin
            if (h_ok && !pool_full) begin
              state_next = dll_pkg::S_INS_AFTER;
            end
          end
          dll_pkg::OP_FIND: begin
            if (!list_empty) begin
              state_next = dll_pkg::S_FIND;
            end
          end
          dll_pkg::OP_DEL_NODE: begin
            if (!list_empty && h_ok) begin
              state_next = dll_pkg::S_UNLINK;
            end
          end
          dll_pkg::OP_DEL_FIRST, dll_pkg::OP_DEL_LAST: begin
            if (!list_empty && head != NIL && tail != NIL) begin
              state_next = dll_pkg::S_UNLINK;
            end
          end
          default: state_next = dll_pkg::S_DONE;
        endcase
      end
      dll_pkg::S_INS_AFTER: state_next = dll_pkg::S_NODE_WR;
      dll_pkg::S_NODE_WR:   state_next = dll_pkg::S_LINK;
      dll_pkg::S_LINK:      state_next = dll_pkg::S_DONE;
      dll_pkg::S_UNLINK:    state_next = dll_pkg::S_DONE;
      dll_pkg::S_FIND: begin
        if (rd_value == val_q || rd_next == NIL) begin
          state_next = dll_pkg::S_DONE;
        end
      end
      dll_pkg::S_DONE: begin
        if (out_free) begin
          state_next = dll_pkg::S_IDLE;
        end
      end
      default: state_next = dll_pkg::S_IDLE;
    endcase
  end

  // Memory and allocator controls.
  always_comb begin
    raddr       = IW'(h_q);
    value_we    = 1'b0;
    next_we     = 1'b0;
    prev_we     = 1'b0;
    value_waddr = n_q[IW-1:0];
    next_waddr  = n_q[IW-1:0];
    prev_waddr  = n_q[IW-1:0];
    next_wdata  = b_q;
    prev_wdata  = a_q;
    set_en      = 1'b0;
    clr_en      = 1'b0;
    clr_idx     = n_q[IW-1:0];
    case (state)
      dll_pkg::S_EXEC: begin
        case (op_q)
          dll_pkg::OP_FIND, dll_pkg::OP_DEL_FIRST: raddr = head[IW-1:0];
          dll_pkg::OP_DEL_LAST:                    raddr = tail[IW-1:0];
          default:                                 raddr = IW'(h_q);
        endcase
      end
      dll_pkg::S_FIND: begin
        raddr = rd_next[IW-1:0];
      end
      dll_pkg::S_NODE_WR: begin
        value_we = 1'b1;
        next_we  = 1'b1;
        prev_we  = 1'b1;
        set_en   = 1'b1;
      end
      dll_pkg::S_LINK: begin
        next_we    = (a_q != NIL);
        next_waddr = a_q[IW-1:0];
        next_wdata = n_q;
        prev_we    = (b_q != NIL);
        prev_waddr = b_q[IW-1:0];
        prev_wdata = n_q;
      end
      dll_pkg::S_UNLINK: begin
        next_we    = (rd_prev != NIL);
        next_waddr = rd_prev[IW-1:0];
        next_wdata = rd_next;
        prev_we    = (rd_next != NIL);
        prev_waddr = rd_next[IW-1:0];
        prev_wdata = rd_prev;
        clr_en     = 1'b1;
      end
      default: begin
        raddr = IW'(h_q);
      end
    endcase
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (state == dll_pkg::S_IDLE && req.valid && req.ready) begin
      op_q     <= req.op;
      val_q    <= req.new_value;
      h_q      <= req.node_handle;
      status_q <= dll_pkg::ST_OK;
      res_q    <= '0;
    end
    case (state)
      dll_pkg::S_EXEC: begin
        case (op_q)
          dll_pkg::OP_INS_HEAD: begin
            n_q <= lowest;
            a_q <= NIL;
            b_q <= head;
            if (pool_full) begin
              status_q <= dll_pkg::ST_FULL;
            end
          end
          dll_pkg::OP_INS_TAIL: begin
            n_q <= lowest;
            a_q <= tail;
            b_q <= NIL;
            if (pool_full) begin
              status_q <= dll_pkg::ST_FULL;
            end
          end
          dll_pkg::OP_INS_AFTER: begin
            n_q <= lowest;
            a_q <= LW'(h_q);
            if (!h_ok) begin
              status_q <= dll_pkg::ST_BAD_HANDLE;
            end else if (pool_full) begin
              status_q <= dll_pkg::ST_FULL;
            end
          end
          dll_pkg::OP_FIND: begin
            n_q <= head;
            if (list_empty) begin
              status_q <= dll_pkg::ST_EMPTY;
            end
          end
          dll_pkg::OP_DEL_NODE: begin
            n_q <= LW'(h_q);
            if (list_empty) begin
              status_q <= dll_pkg::ST_EMPTY;
            end else if (!h_ok) begin
              status_q <= dll_pkg::ST_BAD_HANDLE;
            end
          end
          dll_pkg::OP_DEL_FIRST, dll_pkg::OP_DEL_LAST: begin
            n_q <= (op_q == dll_pkg::OP_DEL_FIRST) ? head : tail;
            if (list_empty || head == NIL || tail == NIL) begin
              status_q <= dll_pkg::ST_EMPTY;
            end
          end
          default: begin
            status_q <= dll_pkg::ST_OK;
          end
        endcase
      end
      dll_pkg::S_INS_AFTER: begin
        b_q <= rd_next;
      end
      dll_pkg::S_LINK: begin
        res_q <= n_q;
      end
      dll_pkg::S_FIND: begin
        if (rd_value == val_q) begin
          res_q <= n_q;
        end else if (rd_next == NIL) begin
          status_q <= dll_pkg::ST_NOT_FOUND;
        end else begin
          n_q <= rd_next;
        end
      end
      default: begin
      end
    endcase
  end

  // List head, tail and count follow each link change.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NIL;
      tail  <= NIL;
      count <= '0;
    end else if (state == dll_pkg::S_LINK) begin
      if (a_q == NIL) begin
        head <= n_q;
      end
      if (b_q == NIL) begin
        tail <= n_q;
      end
      count <= count + 1'b1;
    end else if (state == dll_pkg::S_UNLINK) begin
      if (rd_prev == NIL) begin
        head <= rd_next;
      end
      if (rd_next == NIL) begin
        tail <= rd_prev;
      end
      count <= count - 1'b1;
    end
  end

  // Sequencer state and the response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dll_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dll_pkg::S_DONE && out_free) begin
        out_valid  <= 1'b1;
        out_status <= status_q;
        out_handle <= dll_pkg::HND_W'(res_q);
        out_count  <= dll_pkg::CNT_W'(count);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DLL_ASSERT_NOW(a_count_bound, 1'b1, count <= NIL)
  `DLL_ASSERT_NOW(a_head_empty, 1'b1, (count == '0) == (head == NIL))
  `DLL_ASSERT_NOW(a_tail_empty, 1'b1, (count == '0) == (tail == NIL))
  `DLL_ASSERT_NOW(a_alloc_room, state == dll_pkg::S_NODE_WR, lowest != NIL && !alloc_busy)

endmodule

// ===== src/dll_node_mem.sv =====
module dll_node_mem #(
  parameter int DEPTH = 64,
  parameter int LW    = 7
) (
  input  logic                         clk,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [dll_pkg::VAL_W-1:0]    rd_value,
  output logic [LW-1:0]                rd_next,
  output logic [LW-1:0]                rd_prev,
  input  logic                         value_we,
  input  logic [$clog2(DEPTH)-1:0]     value_waddr,
  input  logic [dll_pkg::VAL_W-1:0]    value_wdata,
  input  logic                         next_we,
  input  logic [$clog2(DEPTH)-1:0]     next_waddr,
  input  logic [LW-1:0]                next_wdata,
  input  logic                         prev_we,
  input  logic [$clog2(DEPTH)-1:0]     prev_waddr,
  input  logic [LW-1:0]                prev_wdata
);

  logic [dll_pkg::VAL_W-1:0] value_mem [DEPTH];
  logic [LW-1:0]             next_mem  [DEPTH];
  logic [LW-1:0]             prev_mem  [DEPTH];

  // Three arrays share one read address; each has its own write port.
  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[value_waddr] <= value_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    rd_value <= value_mem[raddr];
    rd_next  <= next_mem[raddr];
    rd_prev  <= prev_mem[raddr];
  end

endmodule

// ===== src/dll_alloc.sv =====
module dll_alloc #(
  parameter int DEPTH = 64,
  parameter int LW    = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      set_en,
  input  logic                      clr_en,
  input  logic [$clog2(DEPTH)-1:0]  clr_idx,
  input  logic [$clog2(DEPTH)-1:0]  q_idx,
  output logic                      q_used,
  output logic [LW-1:0]             lowest,
  output logic                      busy
);

  localparam int IW  = $clog2(DEPTH);
  localparam int NG  = (DEPTH + 7) / 8;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  logic [DEPTH-1:0]  in_use;
  logic [GIW-1:0]    grp;
  logic [NG*8-1:0]   used_pad;
  logic [7:0]        chunk;
  logic [2:0]        first_free;
  logic              chunk_free;

  // Entries beyond the pool read as used so the scan never picks them.
  always_comb begin
    used_pad = '1;
    used_pad[DEPTH-1:0] = in_use;
    chunk = used_pad[grp*8 +: 8];
    chunk_free = ~&chunk;
    first_free = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!chunk[i]) begin
        first_free = 3'(i);
      end
    end
  end

  assign q_used = in_use[q_idx];

  // Allocation takes the lowest free entry, then scans eight entries a cycle
  // from that group upward for the next free one. A release only lowers the mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      lowest <= '0;
      busy   <= 1'b0;
      grp    <= '0;
    end else if (busy) begin
      if (chunk_free) begin
        lowest <= LW'({grp, first_free});
        busy   <= 1'b0;
      end else if (grp == GIW'(NG - 1)) begin
        lowest <= NIL;
        busy   <= 1'b0;
      end else begin
        grp <= grp + 1'b1;
      end
    end else if (set_en) begin
      in_use[lowest[IW-1:0]] <= 1'b1;
      busy <= 1'b1;
      grp  <= GIW'(lowest >> 3);
    end else if (clr_en) begin
      in_use[clr_idx] <= 1'b0;
      if (LW'(clr_idx) < lowest) begin
        lowest <= LW'(clr_idx);
      end
    end
  end

endmodule
